// ===== rtl/core/nwt_pkg.sv =====
// Shared types, item codes and character-class functions for the name word tokenizer.
// No dependencies; imported by name_word_tokenizer_core.
`default_nettype none

package nwt_pkg;

  // Token codes carried in item_kind
  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_WORD_END = 2'd1;
  localparam logic [1:0] KIND_STR_END  = 2'd2;

  // Most tokens one input byte can release: four bytes, a word end and a string end
  localparam int MAX_TOKENS = 6;
  localparam int TOK_CNT_W  = $clog2(MAX_TOKENS + 1);

  // Lookahead window depth
  localparam int WIN_DEPTH = 3;
  localparam int WIN_CNT_W = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] word_char;
  } token_item_t;

  // ASCII lower-case letters and the 224..255 range lose 32
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h61 && c <= 8'h7a) || c >= 8'd224) r = c - 8'd32;
    return r;
  endfunction

  // Letters, digits, apostrophe, asterisk and the high letter ranges
  function automatic logic plain_word_byte(input logic [7:0] c);
    logic w;
    w = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
        (c >= 8'h61 && c <= 8'h7a) || c == 8'h27 || c == 8'h2a ||
        (c >= 8'd192 && c <= 8'd246) || c >= 8'd248;
    return w;
  endfunction

  // True when the three bytes spell COM, NET, ORG, GOV or EDU after upper-casing
  function automatic logic domain_follows(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [23:0] s;
    s = {upcase(a), upcase(b), upcase(c)};
    return s == {8'h43, 8'h4f, 8'h4d} || s == {8'h4e, 8'h45, 8'h54} ||
           s == {8'h4f, 8'h52, 8'h47} || s == {8'h47, 8'h4f, 8'h56} ||
           s == {8'h45, 8'h44, 8'h55};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/name_word_tokenizer_core.sv =====
// Top level of the name word tokenizer: lookahead window, classifier, token buffer
// and output register. Depends on nwt_pkg.
`default_nettype none

// Takes one byte of a name string per cycle while byte_stall is low and returns
// its words as upper-cased character tokens, each word closed by a word-end token,
// and the string closed by a string-end token. Every byte waits in a three-byte
// window so that a period can be checked against .COM/.NET/.ORG/.GOV/.EDU before
// it is classified; with keep_dots set every period is a word character. A byte
// that is not the last of its string yields at most one token, so strings stream
// at one byte per cycle while token_stall is low; tokens pass through the token
// buffer and the output register. The last byte of a string releases up to six
// tokens at once; these drain from a six-entry token buffer at one per cycle while
// token_stall is low, and the byte port stalls until the buffer is down to its
// final token. keep_dots is written through the cfg port, which is always ready.
module name_word_tokenizer_core (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      byte_valid,
  output logic                     byte_stall,
  input  nwt_pkg::byte_item_t      byte_data,
  output logic                     token_valid,
  input  wire                      token_stall,
  output nwt_pkg::token_item_t     token_data,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire                      cfg_data
);
  import nwt_pkg::*;

  // Configuration and tokenizer state
  logic                 keep_dots;
  logic [7:0]           win [WIN_DEPTH];
  logic [WIN_CNT_W-1:0] win_count;
  logic                 inside_word;

  // Token buffer and its read position
  token_item_t          burst_item [MAX_TOKENS];
  logic [TOK_CNT_W-1:0] burst_cnt;
  logic [TOK_CNT_W-1:0] burst_idx;
  logic [TOK_CNT_W-1:0] burst_left;

  // Handshake control
  logic out_load;
  logic burst_adv;
  logic burst_free;
  logic byte_accept;

  // Next-state values from the classifier
  token_item_t          items_next [MAX_TOKENS];
  logic [TOK_CNT_W-1:0] burst_cnt_next;
  logic [7:0]           win_next [WIN_DEPTH];
  logic [WIN_CNT_W-1:0] win_count_next;
  logic                 inside_word_next;

  assign cfg_ready = 1'b1;

  // Buffer drains into the output register whenever that register can take a token
  assign burst_left  = burst_cnt - burst_idx;
  assign out_load    = !token_valid || !token_stall;
  assign burst_adv   = (burst_left != '0) && out_load;
  assign burst_free  = (burst_left == '0) ||
                       (burst_left == TOK_CNT_W'(1) && burst_adv);
  assign byte_stall  = !burst_free;
  assign byte_accept = byte_valid && burst_free;

  // Classify one step: window bytes plus the new byte, zero past the end
  always_comb begin
    logic [7:0]           seq [7];
    logic [2:0]           m;
    logic                 iw;
    logic                 word;
    logic [TOK_CNT_W-1:0] n;

    m    = {1'b0, win_count} + 3'd1;
    iw   = inside_word;
    word = 1'b0;
    n    = '0;
    for (int i = 0; i < MAX_TOKENS; i++) items_next[i] = '0;
    for (int j = 0; j < 7; j++) begin
      if (j < WIN_DEPTH && 2'(j) < win_count) seq[j] = win[j];
      else if (3'(j) == {1'b0, win_count}) seq[j] = byte_data.in_byte;
      else seq[j] = 8'h00;
    end
    for (int j = 0; j < WIN_DEPTH; j++) win_next[j] = win[j];
    win_count_next = win_count;

    if (byte_data.last_byte) begin
      // Flush the window and the final byte in order
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < m) begin
          word = plain_word_byte(seq[k]);
          if (seq[k] == 8'h2e &&
              (keep_dots || domain_follows(seq[k+1], seq[k+2], seq[k+3])))
            word = 1'b1;
          if (word) begin
            items_next[n] = '{item_kind: KIND_CHAR, word_char: upcase(seq[k])};
            n  = n + TOK_CNT_W'(1);
            iw = 1'b1;
          end else if (iw) begin
            items_next[n] = '{item_kind: KIND_WORD_END, word_char: 8'h00};
            n  = n + TOK_CNT_W'(1);
            iw = 1'b0;
          end
        end
      end
      if (iw) begin
        items_next[n] = '{item_kind: KIND_WORD_END, word_char: 8'h00};
        n = n + TOK_CNT_W'(1);
      end
      items_next[n] = '{item_kind: KIND_STR_END, word_char: 8'h00};
      n  = n + TOK_CNT_W'(1);
      iw = 1'b0;
      win_count_next = '0;
    end else if (win_count != WIN_CNT_W'(WIN_DEPTH)) begin
      // Window still filling: hold the byte only
      for (int j = 0; j < WIN_DEPTH; j++) win_next[j] = seq[j];
      win_count_next = m[WIN_CNT_W-1:0];
    end else begin
      // Classify the oldest byte and advance the window
      word = plain_word_byte(seq[0]);
      if (seq[0] == 8'h2e && (keep_dots || domain_follows(seq[1], seq[2], seq[3])))
        word = 1'b1;
      if (word) begin
        items_next[0] = '{item_kind: KIND_CHAR, word_char: upcase(seq[0])};
        n  = TOK_CNT_W'(1);
        iw = 1'b1;
      end else if (iw) begin
        items_next[0] = '{item_kind: KIND_WORD_END, word_char: 8'h00};
        n  = TOK_CNT_W'(1);
        iw = 1'b0;
      end
      for (int j = 0; j < WIN_DEPTH; j++) win_next[j] = seq[j+1];
    end
    burst_cnt_next   = n;
    inside_word_next = iw;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_dots <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      keep_dots <= cfg_data;
    end
  end

  // Window and word state advance on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      win_count   <= '0;
      inside_word <= 1'b0;
    end else if (byte_accept) begin
      win_count   <= win_count_next;
      inside_word <= inside_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      for (int j = 0; j < WIN_DEPTH; j++) win[j] <= win_next[j];
    end
  end

  // Load the token buffer on a byte transfer, else step through it
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt <= '0;
      burst_idx <= '0;
    end else if (byte_accept) begin
      burst_cnt <= burst_cnt_next;
      burst_idx <= '0;
    end else if (burst_adv) begin
      burst_idx <= burst_idx + TOK_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      for (int i = 0; i < MAX_TOKENS; i++) burst_item[i] <= items_next[i];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (out_load) begin
      token_valid <= burst_left != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_adv) begin
      token_data <= burst_item[burst_idx];
    end
  end

  // Read position never passes the fill count
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    burst_idx <= burst_cnt)
    else $error("token buffer read position past fill count");

  // A string's last byte leaves the tokenizer back at its start state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    byte_accept && byte_data.last_byte |=> win_count == '0 && !inside_word)
    else $error("state not cleared after end of string");

  // A byte that is not the last releases at most one token
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    byte_accept && !byte_data.last_byte |=> burst_cnt <= TOK_CNT_W'(1))
    else $error("mid-string byte released more than one token");

  // A full window stays full until the string ends
  a_win_full: assert property (@(posedge clk) disable iff (rst)
    byte_accept && !byte_data.last_byte && win_count == WIN_CNT_W'(WIN_DEPTH)
    |=> win_count == WIN_CNT_W'(WIN_DEPTH))
    else $error("lookahead window lost a byte");

endmodule

`default_nettype wire
